// File: hdl/mpst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpst_pkg
// Shared types and constants of the mixture proposal scale tuner.
// ----------------------------------------------------------------------------
package mpst_pkg;

  localparam int MAX_COMPONENTS = 16;
  localparam int ADDR_W         = $clog2(MAX_COMPONENTS);

  localparam int RATE_W  = 16;
  localparam int AVG_W   = 17;
  localparam int SCALE_W = 24;
  localparam int K_W     = 5;
  localparam int ENTRY_W = SCALE_W + AVG_W;

  localparam int RL_W     = 2 * RATE_W;
  localparam int GAIN_W   = RL_W + K_W;
  localparam int FACTOR_W = GAIN_W + 1;
  localparam int GAIN_LO_W = 19;
  localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
  localparam int GROW_W   = SCALE_W + GAIN_W - 32;

  localparam int DIV_STEPS = SCALE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [AVG_W-1:0]   ONE_Q16   = 17'd65536;
  localparam logic [SCALE_W-1:0] SCALE_MIN = 24'd105;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 24'd10485760;

  localparam logic [RATE_W-1:0]  TARGET_RST  = 16'd15335;
  localparam logic [RATE_W-1:0]  LR_RST      = 16'd6554;
  localparam logic [AVG_W-1:0]   ALPHA_RST   = 17'd1298;
  localparam logic [K_W-1:0]     NCOMP_RST   = 5'd1;
  localparam logic [SCALE_W-1:0] INIT_SCALE_RST = 24'd1764648;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_WEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COMP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SCALE    = 3'd4;

  localparam logic MODE_REINIT  = 1'b0;
  localparam logic MODE_OUTCOME = 1'b1;

  localparam logic [1:0] DIR_NONE   = 2'd0;
  localparam logic [1:0] DIR_SHRINK = 2'd1;
  localparam logic [1:0] DIR_GROW   = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [3:0]        component;
    logic              accepted;
    logic [RATE_W-1:0] random_fraction;
  } in_req_t;

  typedef struct packed {
    logic [3:0]         out_component;
    logic [AVG_W-1:0]   new_average;
    logic [SCALE_W-1:0] new_scale;
    logic [1:0]         direction;
    logic               saturated;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EMA,
    ST_TEST,
    ST_DECIDE,
    ST_DIV,
    ST_MLO,
    ST_MHI,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hdl/mixture_proposal_scale_tuner_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mixture_proposal_scale_tuner_top
// Per-component proposal scale and acceptance average update.
// reinit and out-of-range results appear in the cycle after start; an outcome
//   steps READ, EMA, TEST, DECIDE, DIV (shrink) or MLO, MHI, SUM (grow), DONE
// a new request is taken only while idle; busy falls as the result strobes
// the 24-step restoring divider computes the shrunk scale; receiver cannot stall
// synchronous active-low reset: all entries invalid, control and config to defaults
// ----------------------------------------------------------------------------
module mixture_proposal_scale_tuner_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire mpst_pkg::in_req_t                  in_req,
  output logic                                    out_strobe,
  output mpst_pkg::out_res_t                      out_res,
  input  wire logic                               cfg_we,
  input  wire logic [mpst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mpst_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int AVG_W   = mpst_pkg::AVG_W;
  localparam int SCALE_W = mpst_pkg::SCALE_W;
  localparam int RATE_W  = mpst_pkg::RATE_W;
  localparam int ADDR_W  = mpst_pkg::ADDR_W;

  // configuration
  logic [RATE_W-1:0]     target_r, lr_r;
  logic [AVG_W-1:0]      alpha_r;
  logic [mpst_pkg::K_W-1:0] ncomp_r;
  logic [SCALE_W-1:0]    init_scale_r;

  // control
  mpst_pkg::state_t      state_r, state_nxt;
  logic [mpst_pkg::MAX_COMPONENTS-1:0] valid_r, valid_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic [mpst_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // datapath
  logic [3:0]            comp_r, comp_nxt;
  logic                  acc_r, acc_nxt;
  logic [RATE_W-1:0]     rnd_r, rnd_nxt;
  logic [AVG_W-1:0]      avg_r, avg_nxt;
  logic [SCALE_W-1:0]    scl_r, scl_nxt;
  logic [2*AVG_W-1:0]    ema_prod_r, ema_prod_nxt;
  logic [mpst_pkg::RL_W-1:0]     rl_r, rl_nxt;
  logic [mpst_pkg::GAIN_W-1:0]   gain_r, gain_nxt;
  logic [mpst_pkg::FACTOR_W-1:0] factor_r, factor_nxt;
  logic [2*AVG_W-1:0]    shr_lhs_r, shr_lhs_nxt;
  logic [AVG_W+RATE_W-1:0] grw_rhs_r, grw_rhs_nxt;
  logic [1:0]            dir_r, dir_nxt;
  logic [mpst_pkg::FACTOR_W-1:0] rem_r, rem_nxt;
  logic [SCALE_W-1:0]    quo_r, quo_nxt;
  logic [SCALE_W+mpst_pkg::GAIN_LO_W-1:0] pp_lo_r, pp_lo_nxt;
  logic [SCALE_W+mpst_pkg::GAIN_HI_W-1:0] pp_hi_r, pp_hi_nxt;
  logic [mpst_pkg::GROW_W-1:0] hi_r, hi_nxt;
  mpst_pkg::out_res_t    out_res_r, out_res_nxt;

  // control outputs
  logic                  accept;
  logic                  ram_we;
  logic                  div_last;

  // ram
  logic [ADDR_W-1:0]             ram_raddr, ram_waddr;
  logic [mpst_pkg::ENTRY_W-1:0]  ram_rdata, ram_wdata;

  // combinational helpers
  logic                  rd_valid;
  logic [AVG_W-1:0]      rd_avg, ema_base, alpha_eff, ema_delta;
  logic [SCALE_W-1:0]    rd_scl, fin_scl;
  logic [mpst_pkg::FACTOR_W:0] div_sh;
  logic                  div_ge, is_shrink, is_grow, fin_sat;
  logic [mpst_pkg::GAIN_W+SCALE_W-1:0] pp_sum;
  logic [mpst_pkg::GROW_W:0] grown;

  assign ram_raddr = ADDR_W'(in_req.component);
  assign ram_waddr = ADDR_W'(comp_r);

  mpst_ram #(
    .WIDTH (mpst_pkg::ENTRY_W),
    .DEPTH (mpst_pkg::MAX_COMPONENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= mpst_pkg::TARGET_RST;
      lr_r         <= mpst_pkg::LR_RST;
      alpha_r      <= mpst_pkg::ALPHA_RST;
      ncomp_r      <= mpst_pkg::NCOMP_RST;
      init_scale_r <= mpst_pkg::INIT_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mpst_pkg::CFG_TARGET_RATE:   target_r     <= cfg_wdata[RATE_W-1:0];
        mpst_pkg::CFG_LEARNING_RATE: lr_r         <= cfg_wdata[RATE_W-1:0];
        mpst_pkg::CFG_AVG_WEIGHT:    alpha_r      <= cfg_wdata[AVG_W-1:0];
        mpst_pkg::CFG_NUM_COMP:      ncomp_r      <= cfg_wdata[mpst_pkg::K_W-1:0];
        mpst_pkg::CFG_INIT_SCALE:    init_scale_r <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpst_pkg::ST_IDLE: begin
        if (start && in_req.mode == mpst_pkg::MODE_OUTCOME &&
            int'(in_req.component) < mpst_pkg::MAX_COMPONENTS) begin
          state_nxt = mpst_pkg::ST_READ;
        end
      end
      mpst_pkg::ST_READ:   state_nxt = mpst_pkg::ST_EMA;
      mpst_pkg::ST_EMA:    state_nxt = mpst_pkg::ST_TEST;
      mpst_pkg::ST_TEST:   state_nxt = mpst_pkg::ST_DECIDE;
      mpst_pkg::ST_DECIDE: begin
        if (is_shrink) begin
          state_nxt = mpst_pkg::ST_DIV;
        end else if (is_grow) begin
          state_nxt = mpst_pkg::ST_MLO;
        end else begin
          state_nxt = mpst_pkg::ST_DONE;
        end
      end
      mpst_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = mpst_pkg::ST_DONE;
        end
      end
      mpst_pkg::ST_MLO:  state_nxt = mpst_pkg::ST_MHI;
      mpst_pkg::ST_MHI:  state_nxt = mpst_pkg::ST_SUM;
      mpst_pkg::ST_SUM:  state_nxt = mpst_pkg::ST_DONE;
      mpst_pkg::ST_DONE: state_nxt = mpst_pkg::ST_IDLE;
      default:           state_nxt = mpst_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy     = 1'b1;
    ram_we   = 1'b0;
    div_last = 1'b0;
    case (state_r)
      mpst_pkg::ST_IDLE: busy = 1'b0;
      mpst_pkg::ST_DIV:  div_last = (cnt_r == mpst_pkg::CNT_W'(mpst_pkg::DIV_STEPS - 1));
      mpst_pkg::ST_DONE: ram_we = 1'b1;
      default: ;
    endcase
  end

  assign accept = start && !busy;

  // datapath
  always_comb begin
    valid_nxt      = valid_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    cnt_nxt        = cnt_r;
    comp_nxt       = comp_r;
    acc_nxt        = acc_r;
    rnd_nxt        = rnd_r;
    avg_nxt        = avg_r;
    scl_nxt        = scl_r;
    ema_prod_nxt   = ema_prod_r;
    rl_nxt         = rl_r;
    gain_nxt       = gain_r;
    factor_nxt     = factor_r;
    shr_lhs_nxt    = shr_lhs_r;
    grw_rhs_nxt    = grw_rhs_r;
    dir_nxt        = dir_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    pp_lo_nxt      = pp_lo_r;
    pp_hi_nxt      = pp_hi_r;
    hi_nxt         = hi_r;

    rd_valid  = valid_r[ram_waddr];
    rd_avg    = rd_valid ? ram_rdata[AVG_W-1:0] : {1'b0, target_r};
    rd_scl    = rd_valid ? ram_rdata[mpst_pkg::ENTRY_W-1:AVG_W] : init_scale_r;
    alpha_eff = (alpha_r > mpst_pkg::ONE_Q16) ? mpst_pkg::ONE_Q16 : alpha_r;
    ema_base  = acc_r ? (mpst_pkg::ONE_Q16 - rd_avg) : rd_avg;
    ema_delta = ema_prod_r[AVG_W+15:16];

    is_shrink = shr_lhs_r < {2'b00, target_r, 16'd0};
    is_grow   = {avg_r, 16'd0} > grw_rhs_r;

    div_sh = {rem_r, 1'b0};
    div_ge = div_sh >= {1'b0, factor_r};

    pp_sum = (mpst_pkg::GAIN_W+SCALE_W)'(pp_lo_r)
           + {pp_hi_r, {mpst_pkg::GAIN_LO_W{1'b0}}};
    grown  = (mpst_pkg::GROW_W+1)'(scl_r) + (mpst_pkg::GROW_W+1)'(hi_r);

    fin_scl = scl_r;
    fin_sat = 1'b0;
    if (dir_r == mpst_pkg::DIR_SHRINK) begin
      if (quo_r < mpst_pkg::SCALE_MIN) begin
        fin_scl = mpst_pkg::SCALE_MIN;
        fin_sat = 1'b1;
      end else begin
        fin_scl = quo_r;
      end
    end else if (dir_r == mpst_pkg::DIR_GROW) begin
      if (grown > (mpst_pkg::GROW_W+1)'(mpst_pkg::SCALE_MAX)) begin
        fin_scl = mpst_pkg::SCALE_MAX;
        fin_sat = 1'b1;
      end else begin
        fin_scl = grown[SCALE_W-1:0];
      end
    end
    ram_wdata = {fin_scl, avg_r};

    case (state_r)
      mpst_pkg::ST_IDLE: begin
        if (accept) begin
          comp_nxt = in_req.component;
          acc_nxt  = in_req.accepted;
          rnd_nxt  = in_req.random_fraction;
          out_res_nxt.out_component = in_req.component;
          out_res_nxt.direction     = mpst_pkg::DIR_NONE;
          out_res_nxt.saturated     = 1'b0;
          if (in_req.mode == mpst_pkg::MODE_REINIT) begin
            valid_nxt = '0;
            out_res_nxt.new_average = {1'b0, target_r};
            out_res_nxt.new_scale   = init_scale_r;
            out_strobe_nxt = 1'b1;
          end else if (int'(in_req.component) >= mpst_pkg::MAX_COMPONENTS) begin
            out_res_nxt.new_average = '0;
            out_res_nxt.new_scale   = '0;
            out_strobe_nxt = 1'b1;
          end
        end
      end
      mpst_pkg::ST_READ: begin
        avg_nxt      = rd_avg;
        scl_nxt      = rd_scl;
        ema_prod_nxt = (2*AVG_W)'(ema_base) * (2*AVG_W)'(alpha_eff);
        rl_nxt       = mpst_pkg::RL_W'(rnd_r) * mpst_pkg::RL_W'(lr_r);
      end
      mpst_pkg::ST_EMA: begin
        avg_nxt  = acc_r ? (avg_r + ema_delta) : (avg_r - ema_delta);
        gain_nxt = mpst_pkg::GAIN_W'(rl_r) * mpst_pkg::GAIN_W'(ncomp_r);
      end
      mpst_pkg::ST_TEST: begin
        shr_lhs_nxt = (2*AVG_W)'(avg_r)
                    * (2*AVG_W)'(mpst_pkg::ONE_Q16 - {1'b0, lr_r});
        grw_rhs_nxt = (AVG_W+RATE_W)'(mpst_pkg::ONE_Q16 + {1'b0, lr_r})
                    * (AVG_W+RATE_W)'(target_r);
        factor_nxt  = {1'b0, gain_r} + (mpst_pkg::FACTOR_W'(1) << 32);
      end
      mpst_pkg::ST_DECIDE: begin
        cnt_nxt = '0;
        quo_nxt = '0;
        rem_nxt = {{(mpst_pkg::FACTOR_W-SCALE_W-8){1'b0}}, scl_r, 8'd0};
        if (is_shrink) begin
          dir_nxt = mpst_pkg::DIR_SHRINK;
        end else if (is_grow) begin
          dir_nxt = mpst_pkg::DIR_GROW;
        end else begin
          dir_nxt = mpst_pkg::DIR_NONE;
        end
      end
      mpst_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + mpst_pkg::CNT_W'(1);
        if (div_ge) begin
          rem_nxt = mpst_pkg::FACTOR_W'(div_sh - {1'b0, factor_r});
          quo_nxt = {quo_r[SCALE_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[mpst_pkg::FACTOR_W-1:0];
          quo_nxt = {quo_r[SCALE_W-2:0], 1'b0};
        end
      end
      mpst_pkg::ST_MLO: begin
        pp_lo_nxt = (SCALE_W+mpst_pkg::GAIN_LO_W)'(scl_r)
                  * (SCALE_W+mpst_pkg::GAIN_LO_W)'(gain_r[mpst_pkg::GAIN_LO_W-1:0]);
      end
      mpst_pkg::ST_MHI: begin
        pp_hi_nxt = (SCALE_W+mpst_pkg::GAIN_HI_W)'(scl_r)
                  * (SCALE_W+mpst_pkg::GAIN_HI_W)'(
                      gain_r[mpst_pkg::GAIN_W-1:mpst_pkg::GAIN_LO_W]);
      end
      mpst_pkg::ST_SUM: hi_nxt = pp_sum[mpst_pkg::GAIN_W+SCALE_W-1:32];
      mpst_pkg::ST_DONE: begin
        valid_nxt[ram_waddr]      = 1'b1;
        out_res_nxt.out_component = comp_r;
        out_res_nxt.new_average   = avg_r;
        out_res_nxt.new_scale     = fin_scl;
        out_res_nxt.direction     = dir_r;
        out_res_nxt.saturated     = fin_sat;
        out_strobe_nxt            = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mpst_pkg::ST_IDLE;
      valid_r      <= '0;
      out_strobe_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      out_strobe_r <= out_strobe_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    comp_r     <= comp_nxt;
    acc_r      <= acc_nxt;
    rnd_r      <= rnd_nxt;
    avg_r      <= avg_nxt;
    scl_r      <= scl_nxt;
    ema_prod_r <= ema_prod_nxt;
    rl_r       <= rl_nxt;
    gain_r     <= gain_nxt;
    factor_r   <= factor_nxt;
    shr_lhs_r  <= shr_lhs_nxt;
    grw_rhs_r  <= grw_rhs_nxt;
    dir_r      <= dir_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    pp_lo_r    <= pp_lo_nxt;
    pp_hi_r    <= pp_hi_nxt;
    hi_r       <= hi_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
`default_nettype wire

// File: hdl/mpst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpst_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module mpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/mpst_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpst_chk
// Port-level checks of the scale tuner, bound to the top level.
// ----------------------------------------------------------------------------
module mpst_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire mpst_pkg::in_req_t  in_req,
  input wire logic               out_strobe,
  input wire mpst_pkg::out_res_t out_res
);

  // a result only appears once the engine is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobed while busy");

  // reinit request answers in the next cycle with no direction and no clamp
  a_reinit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.mode == mpst_pkg::MODE_REINIT) |=>
      (out_strobe && out_res.direction == mpst_pkg::DIR_NONE && !out_res.saturated))
    else $error("reinit request gave no plain result");

  // outcome request occupies the engine
  a_outcome_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req.mode == mpst_pkg::MODE_OUTCOME) |=> (busy && !out_strobe))
    else $error("outcome request did not hold busy");

  // clamping only happens when the scale moved
  a_sat_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.saturated) |->
      (out_res.direction == mpst_pkg::DIR_SHRINK || out_res.direction == mpst_pkg::DIR_GROW))
    else $error("saturated without a scale change");

  // limits hold after a clamp
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.saturated) |->
      (out_res.new_scale == mpst_pkg::SCALE_MIN || out_res.new_scale == mpst_pkg::SCALE_MAX))
    else $error("saturated scale not at a limit");

endmodule

bind mixture_proposal_scale_tuner_top mpst_chk u_mpst_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_req     (in_req),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
`default_nettype wire
